// ----- rtl/lzss_pkg.sv -----
// Shared constants and control/status types for the LZSS decompressor.
package lzss_pkg;

  localparam int unsigned WinAw     = 12;
  localparam int unsigned WinDepth  = 1 << WinAw;
  localparam int unsigned FillW     = WinAw + 1;
  localparam int unsigned LenW      = 32;
  localparam int unsigned CntW      = 5;

  localparam logic [WinAw-1:0] WinStart = WinAw'(4078);
  localparam logic [7:0]       FillByte = 8'h20;
  localparam logic [CntW-1:0]  MinMatch = CntW'(3);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;        // input transfer this cycle
    logic load_flags;     // new flag byte
    logic shift_flags;    // consume one flag
    logic load_match_low; // first match byte
    logic load_copy;      // second match byte: set up offset and count
    logic rd;             // window read at copy offset
    logic emit;           // emit one byte to output and window
    logic emit_copy;      // emitted byte comes from the window read
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic start_req;   // pending input carries stream start
    logic rem_zero;    // no stream active
    logic rem_one;     // next emitted byte is the last
    logic flags_empty; // no flags left, next token byte is a flag byte
    logic cur_flag;    // flag for the next token
    logic copy_last;   // one copy byte left
    logic out_free;    // output register can take a byte
  } dp_status_t;

endpackage

// ----- rtl/lzss_if.sv -----
// Handshake channels of the LZSS decompressor: input, output and configuration.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;
  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface lzss_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] output_length;
  modport source (output valid, output output_length, input ready);
  modport sink   (input valid, input output_length, output ready);
endinterface

// ----- rtl/lzss_dp.sv -----
// LZSS datapath: history window memory, stream counters, flags and output register.
module lzss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lzss_pkg::ctrl_cmd_t           cmd_i,
  output lzss_pkg::dp_status_t          sts_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_start_i,
  input  logic                          cfg_we_i,
  input  logic [lzss_pkg::LenW-1:0]     cfg_len_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o
);

  logic [7:0]                   win_mem [lzss_pkg::WinDepth];

  logic [7:0]                   byte_q;
  logic [lzss_pkg::WinAw-1:0]   wp_q;
  logic [lzss_pkg::FillW-1:0]   fill_q;
  logic [8:0]                   flags_q;
  logic [7:0]                   mlow_q;
  logic [lzss_pkg::LenW-1:0]    rem_q;
  logic [lzss_pkg::LenW-1:0]    olen_q;
  logic [lzss_pkg::WinAw-1:0]   coff_q;
  logic [lzss_pkg::CntW-1:0]    ccnt_q;
  logic [7:0]                   rd_data_q;
  logic                         rd_ok_q;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q;
  logic                         out_last_q;

  logic [lzss_pkg::WinAw-1:0]   rd_dist;
  logic [7:0]                   emit_byte;
  logic                         new_stream;

  assign new_stream = cmd_i.take_in && in_start_i;
  // Written entries form one run from the start position; anything outside reads as fill.
  assign rd_dist    = coff_q - lzss_pkg::WinStart;
  assign emit_byte  = cmd_i.emit_copy ? (rd_ok_q ? rd_data_q : lzss_pkg::FillByte) : byte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      win_mem[wp_q] <= emit_byte;
    end
    if (cmd_i.rd) begin
      rd_data_q <= win_mem[coff_q];
      rd_ok_q   <= {1'b0, rd_dist} < fill_q;
    end
    if (cmd_i.take_in) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.load_copy) begin
      coff_q <= {byte_q[7:4], mlow_q};
      ccnt_q <= {1'b0, byte_q[3:0]} + lzss_pkg::MinMatch;
    end else if (cmd_i.emit && cmd_i.emit_copy) begin
      coff_q <= coff_q + 1'b1;
      ccnt_q <= ccnt_q - 1'b1;
    end
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= (rem_q == lzss_pkg::LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= lzss_pkg::WinStart;
      fill_q      <= '0;
      flags_q     <= '0;
      mlow_q      <= '0;
      rem_q       <= '0;
      olen_q      <= lzss_pkg::LenW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        olen_q <= cfg_len_i;
      end
      if (new_stream) begin
        wp_q    <= lzss_pkg::WinStart;
        fill_q  <= '0;
        flags_q <= '0;
        mlow_q  <= '0;
        rem_q   <= olen_q;
      end else begin
        if (cmd_i.load_flags) begin
          flags_q <= {1'b1, byte_q};
        end else if (cmd_i.shift_flags) begin
          flags_q <= {1'b0, flags_q[8:1]};
        end
        if (cmd_i.load_match_low) begin
          mlow_q <= byte_q;
        end
        if (cmd_i.emit) begin
          rem_q <= rem_q - 1'b1;
          wp_q  <= wp_q + 1'b1;
          if (!fill_q[lzss_pkg::FillW-1]) begin
            fill_q <= fill_q + 1'b1;
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.start_req   = in_start_i;
    sts_o.rem_zero    = (rem_q == '0);
    sts_o.rem_one     = (rem_q == lzss_pkg::LenW'(1));
    sts_o.flags_empty = (flags_q[8:1] == '0);
    sts_o.cur_flag    = flags_q[0];
    sts_o.copy_last   = (ccnt_q == lzss_pkg::CntW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/lzss_ctrl.sv -----
// LZSS controller: token phase tracking and sequencing of literal and match copies.
module lzss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lzss_pkg::dp_status_t sts_i,
  output lzss_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IN,
    ST_DECODE,
    ST_LIT,
    ST_RD,
    ST_WR
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_MATCH
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  phase_e phase_after;

  // Phase once a token is complete
  assign phase_after = sts_i.flags_empty ? PH_FLAG : PH_TOKEN;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = ST_DECODE;
          if (sts_i.start_req) begin
            phase_d = PH_FLAG;
          end
        end
      end
      ST_DECODE: begin
        if (sts_i.rem_zero) begin
          state_d = ST_IN;
        end else if (phase_q == PH_MATCH) begin
          cmd_o.load_copy = 1'b1;
          state_d         = ST_RD;
        end else if (phase_q != PH_TOKEN || sts_i.flags_empty) begin
          cmd_o.load_flags = 1'b1;
          phase_d          = PH_TOKEN;
          state_d          = ST_IN;
        end else begin
          cmd_o.shift_flags = 1'b1;
          if (sts_i.cur_flag) begin
            state_d = ST_LIT;
          end else begin
            cmd_o.load_match_low = 1'b1;
            phase_d              = PH_MATCH;
            state_d              = ST_IN;
          end
        end
      end
      ST_LIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          phase_d    = phase_after;
          state_d    = ST_IN;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_copy = 1'b1;
          if (sts_i.rem_one || sts_i.copy_last) begin
            phase_d = phase_after;
            state_d = ST_IN;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      phase_q <= PH_FLAG;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- rtl/lzss_decompressor.sv -----
// LZSS decompressor top level: controller, datapath and channel hookup.
// Compressed bytes go in one per transfer on in_i, decompressed bytes come out on out_o,
// and the stream length is to be written on cfg_i while the block is idle, which the
// block does not enforce; it is latched when a byte with stream_start arrives, and that
// byte is also the first flag byte. Each input byte is transferred and then decoded; a
// literal is then emitted, and the single-port 4096 x 8 window is read and then written
// back in turn for every copied match byte. The window needs no clearing pass: a fill
// count tracks how much of it the current stream has written, and every other entry
// reads as 0x20, so a new stream can start right after the previous one. A byte waiting
// in the output register holds the block only when the next byte is ready to go out.
module lzss_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzss_in_if.sink     in_i,
  lzss_out_if.source  out_o,
  lzss_cfg_if.sink    cfg_i
);

  lzss_pkg::ctrl_cmd_t  cmd;
  lzss_pkg::dp_status_t sts;

  // Length register always takes its write transfer
  assign cfg_i.ready = 1'b1;

  // Sequencer: token phase, literal and match copy steps
  lzss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window, counters and output register
  lzss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_i.in_byte),
    .in_start_i  (in_i.stream_start),
    .cfg_we_i    (cfg_i.valid),
    .cfg_len_i   (cfg_i.output_length),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last)
  );

`ifndef SYNTHESIS
  // A byte is only emitted into a free output slot
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("byte emitted while output register busy");

  // Nothing is emitted once the stream count has run out
  a_emit_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.rem_zero)
    else $error("byte emitted with no stream active");

  // An emitted byte is presented on the output next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_o.valid)
    else $error("emitted byte not presented");

  // Input is never taken while a byte is being produced
  a_in_vs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !cmd.emit && !cmd.rd)
    else $error("input transfer during copy");
`endif

endmodule
